// ----- hw/rtl/sha256_pkg.sv -----
// sha-256 stream hasher package: types, constants and round functions
// used by the compression core and the top level; no dependencies
`timescale 1ns / 1ps

package sha256_pkg;

   localparam int BlockBytes = 64;
   localparam int Rounds     = 64;
   localparam int LenOffset  = 56;
   localparam logic [7:0] PadByte = 8'h80;

   typedef logic [31:0] word_type;
   typedef word_type [7:0] hash_type;

   // top-level sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_COMP,
      ST_EMIT
   } state_type;

   // compression core control
   typedef struct packed {
      logic start;
      logic load_init;
   } core_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } core_sts_type;

   localparam hash_type InitHash = '{
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

   function automatic word_type round_k(input logic [5:0] idx);
      word_type k;
      case (idx)
         6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
         6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
         6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
         6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
         6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
         6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
         default: k = '0;
      endcase
      return k;
   endfunction

   function automatic word_type rotr(input word_type x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

endpackage

// ----- hw/rtl/sha256_core.sv -----
// sha-256 compression core: one round per cycle over a 16-word schedule window
// depends on sha256_pkg; block words arrive from the top-level block memory
`timescale 1ns / 1ps

module sha256_core (
   input  logic                     clock,
   input  logic                     reset,
   input  sha256_pkg::core_ctl_type ctl,
   input  sha256_pkg::word_type     blk_word,   // block word for round t (t < 16)
   output logic [5:0]               round_idx,
   output sha256_pkg::core_sts_type sts,
   output sha256_pkg::hash_type     hash
);
   import sha256_pkg::*;

   hash_type        h_ff, h_in;
   hash_type        v_ff, v_in;
   word_type [15:0] w_ff, w_in;
   logic [5:0]      t_ff, t_in;
   logic            busy_ff, busy_in;
   logic            fin_ff, fin_in;
   word_type        wt, s0, s1, big0, big1, ch, maj, t1, t2, wnew;

   assign round_idx = t_ff;
   assign sts.busy  = busy_ff | fin_ff;
   assign sts.done  = fin_ff;
   assign hash      = h_ff;

   // one round of the compression
   always_comb begin
      s0   = rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1   = rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
      wnew = w_ff[0] + s0 + w_ff[9] + s1;
      wt   = (t_ff < 6'd16) ? blk_word : wnew;
      big1 = rotr(v_ff[4], 6) ^ rotr(v_ff[4], 11) ^ rotr(v_ff[4], 25);
      ch   = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      t1   = v_ff[7] + big1 + ch + round_k(t_ff) + wt;
      big0 = rotr(v_ff[0], 2) ^ rotr(v_ff[0], 13) ^ rotr(v_ff[0], 22);
      maj  = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t2   = big0 + maj;
   end

   // sequencing of rounds and the final add
   always_comb begin
      h_in    = h_ff;
      v_in    = v_ff;
      w_in    = w_ff;
      t_in    = t_ff;
      busy_in = busy_ff;
      fin_in  = 1'b0;
      if (ctl.load_init) begin
         h_in = InitHash;
      end
      if (ctl.start && !busy_ff) begin
         busy_in = 1'b1;
         t_in    = '0;
         v_in    = h_ff;
      end else if (busy_ff) begin
         // window at round t, before the shift: w_ff[k] is w[t-16+k]
         w_in = {wt, w_ff[15:1]};
         v_in = {v_ff[6], v_ff[5], v_ff[4], v_ff[3] + t1,
                 v_ff[2], v_ff[1], v_ff[0], t1 + t2};
         t_in = t_ff + 6'd1;
         if (t_ff == 6'(Rounds - 1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end
      if (fin_ff) begin
         for (int i = 0; i < 8; i++) begin
            h_in[i] = h_ff[i] + v_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         t_ff    <= '0;
         h_ff    <= InitHash;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         t_ff    <= t_in;
         h_ff    <= h_in;
      end
      v_ff <= v_in;
      w_ff <= w_in;
   end

`ifndef SYNTH
   a_fin_after_last: assert property (@(posedge clock) disable iff (reset)
      busy_ff && t_ff == 6'd63 |=> fin_ff) else $error("round end lost");
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      fin_ff |-> !busy_ff) else $error("core busy during final add");
   a_round_step: assert property (@(posedge clock) disable iff (reset)
      busy_ff && t_ff != 6'd63 |=> busy_ff && t_ff == $past(t_ff) + 6'd1)
      else $error("round counter skipped");
`endif

endmodule

// ----- hw/rtl/sha256_stream_hasher.sv -----
// sha-256 stream hasher top level: byte intake, block memory, padding, digest
// depends on sha256_pkg and sha256_core
`timescale 1ns / 1ps

// Takes a message one byte per transaction and returns its SHA-256 digest as
// eight 32-bit words (H0 first) after a transaction with the end flag. Bytes
// are written into a 16-word block memory with a registered read port, one
// transaction per cycle; when a transaction completes 64 bytes, intake stops
// while the block is compressed (start, 64 rounds at one per cycle, final
// add), the core reading block words from the memory for the first 16
// rounds. At the end the block pads (0x80, zeros, 64-bit length) one byte
// per cycle, compressing once or twice, then presents the digest words, one
// per accepted result transaction, and restores the initial hash values.
module sha256_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] data_byte, [8] byte_present, rest zero
   input  logic        req_tlast,   // end_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] digest_word, [34:32] word_index
   output logic        rsp_tlast    // last_word
);
   import sha256_pkg::*;

   // block memory, 16 big-endian words with byte enables
   word_type      mem [16];
   word_type      rd_ff;
   logic          we;
   logic [3:0]    wa;
   logic [3:0]    ra;
   logic [1:0]    wb;
   logic [7:0]    wd;

   state_type     st_ff, st_in;
   logic [5:0]    fill_ff, fill_in;
   logic [60:0]   cnt_ff, cnt_in;
   logic          eom_ff, eom_in;         // end was seen, padding owed
   logic          mark_ff, mark_in;       // 0x80 already written
   logic          len_ok_ff, len_ok_in;   // length may go in this block
   logic          fin_blk_ff, fin_blk_in; // block in the core holds the length
   logic          started_ff, started_in;
   logic [2:0]    oidx_ff, oidx_in;
   logic          acc, rsp_acc;
   logic          push;
   logic [7:0]    pbyte;
   logic [63:0]   bits;
   logic [5:0]    ridx;
   core_ctl_type  ctl;
   core_sts_type  sts;
   hash_type      hash;

   sha256_core u_core (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .blk_word (rd_ff),
      .round_idx(ridx),
      .sts      (sts),
      .hash     (hash)
   );

   assign acc     = req_tvalid & req_tready;
   assign rsp_acc = rsp_tvalid & rsp_tready;
   assign bits    = {cnt_ff, 3'b000};

   // byte to store this cycle
   always_comb begin
      push  = 1'b0;
      pbyte = req_tdata[7:0];
      if (st_ff == ST_IDLE) begin
         push = acc & req_tdata[8];
      end else if (st_ff == ST_PAD) begin
         push = 1'b1;
         if (!mark_ff) pbyte = PadByte;
         else if (len_ok_ff && fill_ff >= 6'(LenOffset))
            pbyte = bits[{~fill_ff[2:0], 3'b000} +: 8];
         else pbyte = 8'h00;
      end
   end

   assign we = push;
   assign wa = fill_ff[5:2];
   assign wb = fill_ff[1:0];
   assign wd = pbyte;
   // prefetch: round t reads word t, addressed the cycle before through rd_ff
   assign ra = (st_ff == ST_COMP && sts.busy) ? 4'(ridx + 6'd1) : 4'd0;

   // writes only outside compress, read data used only during it, so no overlap
   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa][{~wb, 3'b000} +: 8] <= wd;
      end
      rd_ff <= mem[ra];
   end

   // next state
   always_comb begin
      st_in      = st_ff;
      fill_in    = fill_ff;
      cnt_in     = cnt_ff;
      eom_in     = eom_ff;
      mark_in    = mark_ff;
      len_ok_in  = len_ok_ff;
      fin_blk_in = fin_blk_ff;
      oidx_in    = oidx_ff;
      if (push) fill_in = fill_ff + 6'd1;
      case (st_ff)
         ST_IDLE: begin
            if (acc) begin
               if (req_tdata[8]) cnt_in = cnt_ff + 61'd1;
               if (req_tlast) eom_in = 1'b1;
               if (push && fill_ff == 6'(BlockBytes - 1)) st_in = ST_COMP;
               else if (req_tlast) st_in = ST_PAD;
            end
         end
         ST_PAD: begin
            if (!mark_ff) begin
               mark_in   = 1'b1;
               len_ok_in = (fill_ff < 6'(LenOffset));
            end
            if (fill_ff == 6'(BlockBytes - 1)) begin
               st_in      = ST_COMP;
               fin_blk_in = mark_ff && len_ok_ff;
            end
         end
         ST_COMP: begin
            if (sts.done) begin
               if (fin_blk_ff) begin
                  st_in = ST_EMIT;
               end else if (eom_ff) begin
                  st_in     = ST_PAD;
                  len_ok_in = 1'b1;
               end else begin
                  st_in = ST_IDLE;
               end
            end
         end
         ST_EMIT: begin
            if (rsp_acc) begin
               oidx_in = oidx_ff + 3'd1;
               if (oidx_ff == 3'd7) begin
                  st_in      = ST_IDLE;
                  cnt_in     = '0;
                  eom_in     = 1'b0;
                  mark_in    = 1'b0;
                  fin_blk_in = 1'b0;
               end
            end
         end
         default: st_in = ST_IDLE;
      endcase
      // start the core once on entry to compress
      started_in = (st_ff == ST_COMP) && (st_in == ST_COMP);
   end

   // outputs
   always_comb begin
      req_tready    = (st_ff == ST_IDLE);
      ctl.start     = (st_ff == ST_COMP) && !started_ff;
      ctl.load_init = rsp_acc && oidx_ff == 3'd7;
      rsp_tvalid    = (st_ff == ST_EMIT);
      rsp_tdata     = {5'd0, oidx_ff, hash[oidx_ff]};
      rsp_tlast     = (oidx_ff == 3'd7);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff      <= ST_IDLE;
         fill_ff    <= '0;
         cnt_ff     <= '0;
         eom_ff     <= 1'b0;
         mark_ff    <= 1'b0;
         len_ok_ff  <= 1'b0;
         fin_blk_ff <= 1'b0;
         oidx_ff    <= '0;
         started_ff <= 1'b0;
      end else begin
         st_ff      <= st_in;
         fill_ff    <= fill_in;
         cnt_ff     <= cnt_in;
         eom_ff     <= eom_in;
         mark_ff    <= mark_in;
         len_ok_ff  <= len_ok_in;
         fin_blk_ff <= fin_blk_in;
         oidx_ff    <= oidx_in;
         started_ff <= started_in;
      end
   end

`ifndef SYNTH
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid) else $error("intake open during digest");
   a_emit_wrap: assert property (@(posedge clock) disable iff (reset)
      rsp_acc && rsp_tlast |=> st_ff == ST_IDLE) else $error("digest end lost");
   a_core_in_comp: assert property (@(posedge clock) disable iff (reset)
      sts.busy |-> st_ff == ST_COMP) else $error("core runs outside compress");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while waiting");
`endif

endmodule

// ----- test/sha256_checker.sv -----
// sha-256 stream hasher checker: watches request and response transactions,
// computes the expected digest words and compares; depends on sha256_pkg
`timescale 1ns / 1ps

module sha256_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   input  logic        rsp_tlast,
   output int          error_count,
   output int          digest_words_pending
);
   import sha256_pkg::*;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_item_type;

   localparam logic [31:0] Kt [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   localparam logic [31:0] H0 [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   logic [31:0]     running_hash [8];
   logic [7:0]      block_bytes [64];
   logic [6:0]      fill_count;
   logic [60:0]     length_bytes;
   digest_item_type expected_digest [$];

   function automatic logic [31:0] ror(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // one 64-round compression of the collected block
   task automatic compress();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2;
      for (int i = 0; i < 16; i++)
         w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
      for (int i = 16; i < 64; i++)
         w[i] = w[i-16] + w[i-7]
              + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
              + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
      v = running_hash;
      for (int i = 0; i < 64; i++) begin
         t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + Kt[i] + w[i];
         t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) running_hash[i] += v[i];
   endtask

   task automatic absorb_byte(logic [7:0] b);
      block_bytes[fill_count[5:0]] = b;
      fill_count++;
      if (fill_count == 7'd64) begin
         compress();
         fill_count = '0;
      end
   endtask

   // pad, emit eight expected words, restore initial state
   task automatic finish_message();
      logic [63:0] bit_len;
      digest_item_type d;
      bit_len = {length_bytes, 3'b000};
      absorb_byte(8'h80);
      while (fill_count != 7'd56) absorb_byte(8'h00);
      for (int i = 0; i < 8; i++) absorb_byte(bit_len[63-8*i -: 8]);
      for (int i = 0; i < 8; i++) begin
         d.word = running_hash[i];
         d.index = i[2:0];
         d.last = (i == 7);
         expected_digest.push_back(d);
      end
      running_hash = H0;
      fill_count = '0;
      length_bytes = '0;
   endtask

   assign digest_words_pending = expected_digest.size();

   // prediction and comparison at each clock edge
   always @(posedge clock) begin
      digest_item_type d;
      if (reset) begin
         running_hash = H0;
         fill_count = '0;
         length_bytes = '0;
         error_count = 0;
         expected_digest.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_digest.size() == 0) begin
               $display("%0t: unexpected result transaction %h", $time, rsp_tdata);
               error_count++;
            end else begin
               d = expected_digest.pop_front();
               if (rsp_tdata[31:0] !== d.word || rsp_tdata[34:32] !== d.index
                   || rsp_tlast !== d.last) begin
                  $display("%0t: mismatch expected word %h index %0d last %b, actual %h %0d %b",
                     $time, d.word, d.index, d.last, rsp_tdata[31:0], rsp_tdata[34:32],
                     rsp_tlast);
                  error_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tdata[8]) begin
               absorb_byte(req_tdata[7:0]);
               length_bytes++;
            end
            if (req_tlast) finish_message();
         end
      end
   end
endmodule

// ----- test/tb.sv -----
// testbench top for sha256_stream_hasher: clock, reset, byte stream stimulus
// and verdict; depends on sha256_stream_hasher and sha256_checker
`timescale 1ns / 1ps

module tb;
   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        req_tlast = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;
   int          error_count;
   int          digest_words_pending;
   int          idle_cycles = 0;
   int          item_count = 0;

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   sha256_stream_hasher uut (.*);
   sha256_checker check (.*);

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 80);
   endfunction

   // send one transaction, with a random gap before it when allow_gap is set
   task automatic send(logic [7:0] b, logic present, logic eom, bit allow_gap = 1);
      int g;
      g = allow_gap ? gap_length() : 0;
      if (g > 0) begin
         req_tvalid <= 0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {7'b0, present, b};
      req_tlast <= eom;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      item_count++;
   endtask

   task automatic send_message(int len, bit calm);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 9) == 0) send(8'($urandom), 0, 0, !calm);
         send(8'($urandom), 1, (i == len - 1) && $urandom_range(0, 1), !calm);
      end
      if (!req_tlast || len == 0) send(8'($urandom), 0, 1, !calm);
   endtask

   // result side stalls
   always @(posedge clock) begin
      if (reset) rsp_tready <= 0;
      else if ($urandom_range(0, 199) < 3) rsp_tready <= 0;
      else if (!rsp_tready) rsp_tready <= ($urandom_range(0, 19) == 0);
      else rsp_tready <= ($urandom_range(0, 3) != 0);
   end

   // watchdog on accepted transactions
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("tb: errors");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: empty message, single bytes at extremes, byte with a separate end
      send(8'hff, 0, 1);
      send(8'h00, 1, 1);
      send(8'hff, 1, 1);
      send(8'ha5, 0, 0);
      send(8'h5a, 1, 0);
      send(8'h00, 0, 1);
      // length that forces a second padding block, and an exact full block
      send_message(56, 0);
      send_message(64, 1);
      // hold off until all digest words are back
      req_tvalid <= 0;
      @(posedge clock);
      while (digest_words_pending != 0) @(posedge clock);
      send_message(55, 0);
      // random short messages
      while (item_count < 200) begin
         send_message($urandom_range(0, 20), $urandom_range(0, 4) == 0);
      end
      req_tvalid <= 0;
      req_tlast <= 0;
      @(posedge clock);
      while (digest_words_pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (error_count == 0) $display("tb: clean");
      else $display("tb: errors");
      $finish;
   end
endmodule
